FILE: rtl/core/slp_pkg.sv
package slp_pkg;

  localparam int BOUND_WIDTH     = 32;
  localparam int MAX_THREADS_DEF = 64;
  localparam int TC_WIDTH        = 7;
  localparam int TID_WIDTH       = 6;
  localparam int KIND_WIDTH      = 8;
  localparam int STATUS_WIDTH    = 2;

  localparam logic [KIND_WIDTH-1:0] SCHED_STATIC = 8'd34;

  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_BAD_KIND  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_ZERO_STEP = 2'd2;

  typedef struct packed {
    logic signed [BOUND_WIDTH-1:0] lower_bound;
    logic signed [BOUND_WIDTH-1:0] upper_bound;
    logic signed [BOUND_WIDTH-1:0] step;
    logic [KIND_WIDTH-1:0]         sched_kind;
    logic [TID_WIDTH-1:0]          thread_index;
  } in_word_t;

  typedef struct packed {
    logic signed [BOUND_WIDTH-1:0] chunk_lower;
    logic signed [BOUND_WIDTH-1:0] chunk_upper;
    logic                          is_last_chunk;
    logic                          partitioned;
    logic [STATUS_WIDTH-1:0]       status;
  } out_word_t;

  typedef struct packed {
    logic [BOUND_WIDTH-1:0]  lo;
    logic [BOUND_WIDTH-1:0]  hi;
    logic [BOUND_WIDTH-1:0]  st;
    logic [TID_WIDTH-1:0]    tid;
    logic [TC_WIDTH-1:0]     nt;
    logic                    pos;
    logic                    pass;
    logic [STATUS_WIDTH-1:0] status;
  } ctx_t;

endpackage

FILE: rtl/core/static_loop_partition.sv
// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_ready    slp_pkg::in_word_t
// out_     output     out_valid / out_ready  slp_pkg::out_word_t
// cfg_     input      cfg_we                 thread_count, 7 bits
//
// A word passes from acceptance through the input register, the two bit-per-stage dividers
// and the sa to se stages to the output register; one word can enter every cycle unless stalled.
// Reset is synchronous and active low; it clears all valid bits and sets thread_count to 1.
// The whole pipeline advances together and holds while a result waits and out_ready is low.
module static_loop_partition #(
  parameter int MAX_THREADS = slp_pkg::MAX_THREADS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  slp_pkg::in_word_t       in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output slp_pkg::out_word_t      out_word,
  input  logic                    cfg_we,
  input  logic [slp_pkg::TC_WIDTH-1:0] cfg_wdata
);

  localparam int W   = slp_pkg::BOUND_WIDTH;
  localparam int TW  = slp_pkg::TC_WIDTH;
  localparam int IW  = slp_pkg::TID_WIDTH;
  localparam int CW  = $bits(slp_pkg::ctx_t);

  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  logic          en;
  logic [TW-1:0] tc_r;

  logic [TW-1:0]     nt_c;
  logic              pos_c;
  logic              neg_c;
  logic              inv_c;
  slp_pkg::ctx_t     ctx_c;
  logic [W-1:0]      span_c;
  logic [W-1:0]      dvs_c;

  logic              s0_v_r;
  slp_pkg::ctx_t     s0_ctx_r;
  logic [W-1:0]      s0_span_r;
  logic [W-1:0]      s0_dvs_r;

  logic              d1_v;
  logic [W-1:0]      d1_quo;
  logic [W-1:0]      d1_rem;
  logic [CW-1:0]     d1_side;
  slp_pkg::ctx_t     d1_ctx;

  logic              d2_v;
  logic [W-1:0]      d2_quo;
  logic [TW-1:0]     d2_rem;
  logic [CW+W-1:0]   d2_side;

  logic              sa_v_r;
  slp_pkg::ctx_t     sa_ctx_r;
  logic [W-1:0]      sa_m_r;
  logic [W:0]        sa_whole_r;
  logic [TW-1:0]     sa_left_r;

  logic [W+IW:0]     wt_full;
  logic              sb_v_r;
  slp_pkg::ctx_t     sb_ctx_r;
  logic [W-1:0]      sb_m_r;
  logic [W:0]        sb_whole_r;
  logic [W:0]        sb_wt_r;
  logic [TW-1:0]     sb_minv_r;
  logic              sb_inc_r;
  logic              sb_tok_r;

  logic              sc_v_r;
  slp_pkg::ctx_t     sc_ctx_r;
  logic [W-1:0]      sc_m_r;
  logic [W:0]        sc_start_r;
  logic [W:0]        sc_nm1_r;
  logic              sc_empty_r;

  logic              sd_v_r;
  slp_pkg::ctx_t     sd_ctx_r;
  logic [W-1:0]      sd_p1_r;
  logic [W-1:0]      sd_p2_r;
  logic              sd_last_r;
  logic              sd_empty_r;

  logic              se_v_r;
  slp_pkg::ctx_t     se_ctx_r;
  logic [W-1:0]      se_clo_r;
  logic [W-1:0]      se_p2_r;
  logic              se_last_r;
  logic              se_empty_r;

  logic               out_v_r;
  slp_pkg::out_word_t out_r;
  slp_pkg::out_word_t out_nxt;

  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TW'(1);
    end else if (cfg_we) begin
      tc_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (tc_r == '0) begin
      nt_c = TW'(1);
    end else if (32'(tc_r) > 32'(MAX_THREADS)) begin
      nt_c = TW'(MAX_THREADS);
    end else begin
      nt_c = tc_r;
    end
    neg_c  = in_word.step[W-1];
    pos_c  = (in_word.step != '0) && !neg_c;
    inv_c  = (pos_c && (in_word.lower_bound > in_word.upper_bound))
          || (neg_c && (in_word.lower_bound < in_word.upper_bound));
    ctx_c.lo  = in_word.lower_bound;
    ctx_c.hi  = in_word.upper_bound;
    ctx_c.st  = in_word.step;
    ctx_c.tid = in_word.thread_index;
    ctx_c.nt  = nt_c;
    ctx_c.pos = pos_c;
    if (nt_c == TW'(1) || inv_c) begin
      ctx_c.status = slp_pkg::ST_OK;
      ctx_c.pass   = 1'b1;
    end else if (in_word.sched_kind != slp_pkg::SCHED_STATIC) begin
      ctx_c.status = slp_pkg::ST_BAD_KIND;
      ctx_c.pass   = 1'b1;
    end else if (in_word.step == '0) begin
      ctx_c.status = slp_pkg::ST_ZERO_STEP;
      ctx_c.pass   = 1'b1;
    end else begin
      ctx_c.status = slp_pkg::ST_OK;
      ctx_c.pass   = 1'b0;
    end
    span_c = pos_c ? (in_word.upper_bound - in_word.lower_bound)
                   : (in_word.lower_bound - in_word.upper_bound);
    dvs_c  = pos_c ? in_word.step : (W'(0) - in_word.step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
      sc_v_r  <= 1'b0;
      sd_v_r  <= 1'b0;
      se_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r  <= in_valid;
      sa_v_r  <= d2_v;
      sb_v_r  <= sa_v_r;
      sc_v_r  <= sb_v_r;
      sd_v_r  <= sc_v_r;
      se_v_r  <= sd_v_r;
      out_v_r <= se_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctx_r  <= ctx_c;
      s0_span_r <= span_c;
      s0_dvs_r  <= dvs_c;
    end
  end

  slp_div #(.DW(W), .VW(W), .SW(CW)) u_span_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_num    (s0_span_r),
    .in_den    (s0_dvs_r),
    .in_side   (s0_ctx_r),
    .out_valid (d1_v),
    .out_quo   (d1_quo),
    .out_rem   (d1_rem),
    .out_side  (d1_side)
  );

  assign d1_ctx = d1_side;

  slp_div #(.DW(W), .VW(TW), .SW(CW + W)) u_team_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d1_v),
    .in_num    (d1_quo),
    .in_den    (d1_ctx.nt),
    .in_side   ({d1_side, d1_quo ^ (d1_rem & '0)}),
    .out_valid (d2_v),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem),
    .out_side  (d2_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sa_ctx_r <= d2_side[CW+W-1:W];
      sa_m_r   <= d2_side[W-1:0];
      if ((TW+1)'(d2_rem) + (TW+1)'(1) == {1'b0, d2_side[W+TW+3:W+4]}) begin
        sa_whole_r <= {1'b0, d2_quo} + (W+1)'(1);
        sa_left_r  <= '0;
      end else begin
        sa_whole_r <= {1'b0, d2_quo};
        sa_left_r  <= d2_rem + TW'(1);
      end
    end
  end

  assign wt_full = (W+IW+1)'(sa_whole_r) * (W+IW+1)'(sa_ctx_r.tid);

  always_ff @(posedge clk) begin
    if (en) begin
      sb_ctx_r   <= sa_ctx_r;
      sb_m_r     <= sa_m_r;
      sb_whole_r <= sa_whole_r;
      sb_wt_r    <= wt_full[W:0];
      sb_inc_r   <= (TW'(sa_ctx_r.tid) < sa_left_r);
      sb_minv_r  <= (TW'(sa_ctx_r.tid) < sa_left_r) ? TW'(sa_ctx_r.tid) : sa_left_r;
      sb_tok_r   <= (TW'(sa_ctx_r.tid) < sa_ctx_r.nt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_ctx_r   <= sb_ctx_r;
      sc_m_r     <= sb_m_r;
      sc_start_r <= sb_wt_r + (W+1)'(sb_minv_r);
      if (sb_tok_r) begin
        sc_nm1_r   <= sb_whole_r + (W+1)'(sb_inc_r) - (W+1)'(1);
        sc_empty_r <= (sb_whole_r == '0) && !sb_inc_r;
      end else begin
        sc_nm1_r   <= '1;
        sc_empty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_ctx_r   <= sc_ctx_r;
      sd_p1_r    <= sc_ctx_r.st * sc_start_r[W-1:0];
      sd_p2_r    <= sc_ctx_r.st * sc_nm1_r[W-1:0];
      sd_last_r  <= ((sc_start_r + sc_nm1_r) == {1'b0, sc_m_r});
      sd_empty_r <= sc_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_ctx_r   <= sd_ctx_r;
      se_clo_r   <= sd_ctx_r.lo + sd_p1_r;
      se_p2_r    <= sd_p2_r;
      se_last_r  <= sd_last_r;
      se_empty_r <= sd_empty_r;
    end
  end

  always_comb begin
    out_nxt.chunk_lower   = se_ctx_r.lo;
    out_nxt.chunk_upper   = se_ctx_r.hi;
    out_nxt.is_last_chunk = 1'b0;
    out_nxt.partitioned   = 1'b0;
    out_nxt.status        = se_ctx_r.status;
    if (!se_ctx_r.pass) begin
      out_nxt.partitioned = 1'b1;
      out_nxt.status      = slp_pkg::ST_OK;
      if (se_empty_r) begin
        out_nxt.chunk_lower = se_ctx_r.pos ? MAX_POS : MIN_NEG;
        out_nxt.chunk_upper = se_ctx_r.pos ? MIN_NEG : MAX_POS;
      end else begin
        out_nxt.chunk_lower   = se_clo_r;
        out_nxt.chunk_upper   = se_clo_r + se_p2_r;
        out_nxt.is_last_chunk = se_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_err_not_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.status != slp_pkg::ST_OK) |-> !out_r.partitioned)
    else $error("error status with a partitioned result");

  a_last_needs_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.is_last_chunk |-> out_r.partitioned)
    else $error("last-chunk flag without partitioning");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s0_v_r) && $stable(se_v_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: rtl/core/slp_div.sv
module slp_div #(
  parameter int DW = 32,
  parameter int VW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic          v_s    [DW+1];
  logic [VW-1:0] rem_s  [DW+1];
  logic [DW-1:0] num_s  [DW+1];
  logic [VW-1:0] den_s  [DW+1];
  logic [SW-1:0] side_s [DW+1];

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = '0;
  assign num_s[0]  = in_num;
  assign den_s[0]  = in_den;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_s[i], num_s[i][DW-1]};
      diff    = trial - {1'b0, den_s[i]};
      ge      = (trial >= {1'b0, den_s[i]});
      rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= rem_nxt;
        num_s[i+1]  <= {num_s[i][DW-2:0], ge};
        den_s[i+1]  <= den_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = v_s[DW];
  assign out_quo   = num_s[DW];
  assign out_rem   = rem_s[DW];
  assign out_side  = side_s[DW];

endmodule
